FILE: hw/rtl/iqmfd_pkg.sv
// ----------------------------------------------------------------------------
// IQ/mic frame demux package
// Shared types and constants for the receiver frame byte demultiplexer.
// ----------------------------------------------------------------------------
package iqmfd_pkg;

  localparam int unsigned IQ_BYTES_PER_RX     = 6;
  localparam int unsigned MIC_BYTES_PER_GROUP = 2;
  localparam int unsigned BASE_RATE_HZ        = 48000;

  typedef enum logic [1:0] {
    KIND_IQ   = 2'd0,
    KIND_MIC  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RATE_48K  = 2'd0,
    RATE_96K  = 2'd1,
    RATE_192K = 2'd2,
    RATE_384K = 2'd3
  } rate_e;

  typedef enum logic [1:0] {
    REG_RX_COUNT = 2'd0,
    REG_SAMPLES  = 2'd1,
    REG_RATE     = 2'd2
  } cfg_reg_e;

  localparam logic [1:0] SKIP_AT_192K = 2'd1;
  localparam logic [1:0] SKIP_AT_384K = 2'd3;

  typedef struct packed {
    logic [3:0] rx_count;
    logic [9:0] samples;
    rate_e      rate;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       frame_end;
    logic       taken;
  } result_t;

endpackage

FILE: hw/rtl/iq_mic_frame_demux.sv
// ----------------------------------------------------------------------------
// IQ/mic frame demultiplexer
// Tags each byte of a receiver frame as a kept IQ byte, a kept mic byte or
// a dropped byte, and passes it through with frame and skip status.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   data_byte, frame_last
//  out      output     out_valid / out_stall out_byte, stream_kind, frame_end,
//                                            mic_block_taken
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle while the queue is not full; its result is registered in the queue.
// The classifier updates all frame counters in the cycle of acceptance.
// A two-entry queue holds results, so the input stalls only when it is full.
// Reset loads the register defaults and arms a frame restart on the next byte.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module iq_mic_frame_demux #(
  parameter int MAX_RECEIVERS = 8,
  parameter int MAX_SAMPLES   = 1023
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] stream_kind_o,
  output logic       frame_end_o,
  output logic       mic_block_taken_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  iqmfd_pkg::cfg_t    cfg_q, cfg_d;
  iqmfd_pkg::result_t result;
  iqmfd_pkg::result_t head;
  logic               full;
  logic               accept;
  logic               pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        iqmfd_pkg::REG_RX_COUNT: cfg_d.rx_count = cfg_data_i[3:0];
        iqmfd_pkg::REG_SAMPLES:  cfg_d.samples  = cfg_data_i;
        iqmfd_pkg::REG_RATE:     cfg_d.rate     = iqmfd_pkg::rate_e'(cfg_data_i[1:0]);
        default:                 cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rx_count: 4'd1, samples: 10'd63, rate: iqmfd_pkg::RATE_48K};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign pop        = out_valid_o && !out_stall_i;

  iqmfd_classify #(
    .MaxReceivers(MAX_RECEIVERS),
    .MaxSamples  (MAX_SAMPLES)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .frame_last_i(frame_last_i),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  iqmfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(result),
    .full_o     (full),
    .valid_o    (out_valid_o),
    .pop_i      (pop),
    .head_o     (head)
  );

  assign out_byte_o        = head.out_byte;
  assign stream_kind_o     = head.kind;
  assign frame_end_o       = head.frame_end;
  assign mic_block_taken_o = head.taken;

endmodule

FILE: hw/rtl/iqmfd_classify.sv
// ----------------------------------------------------------------------------
// IQ/mic frame demux classifier
// Front end: tracks group and frame counters and tags each accepted byte.
// ----------------------------------------------------------------------------
module iqmfd_classify #(
  parameter int MaxReceivers = 8,
  parameter int MaxSamples   = 1023
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_last_i,
  input  iqmfd_pkg::cfg_t    cfg_i,
  output iqmfd_pkg::result_t result_o
);

  localparam int RxW  = $clog2(MaxReceivers + 1);
  localparam int SmpW = $clog2(MaxSamples + 1);
  localparam int GrpW = $clog2(MaxReceivers * iqmfd_pkg::IQ_BYTES_PER_RX + 1);
  localparam int IqW  = $clog2(MaxSamples * MaxReceivers * iqmfd_pkg::IQ_BYTES_PER_RX + 1);
  localparam int MicW = $clog2(MaxSamples * iqmfd_pkg::MIC_BYTES_PER_GROUP + 1);

  logic            frame_start_q, frame_start_d;
  logic            mic_phase_q, mic_phase_d;
  logic [GrpW-1:0] grp_q, grp_d;
  logic [IqW-1:0]  iq_left_q, iq_left_d;
  logic [MicW-1:0] mic_left_q, mic_left_d;
  logic [1:0]      skip_q, skip_d;

  logic [RxW-1:0]  rx_eff;
  logic [SmpW-1:0] smp_eff;
  logic [GrpW-1:0] rx_bytes;
  logic [IqW-1:0]  iq_total;
  logic [MicW-1:0] mic_total;
  logic            cur_mic;
  logic [GrpW-1:0] cur_grp;
  logic [GrpW-1:0] grp_dec;
  logic [IqW-1:0]  cur_iq;
  logic [MicW-1:0] cur_mic_left;
  logic            taken;
  iqmfd_pkg::kind_e kind;
  logic [1:0]      skip_reload;

  always_comb begin
    if (cfg_i.rx_count == 4'd0) begin
      rx_eff = RxW'(1);
    end else if (32'(cfg_i.rx_count) > MaxReceivers) begin
      rx_eff = RxW'(MaxReceivers);
    end else begin
      rx_eff = RxW'(cfg_i.rx_count);
    end
    if (32'(cfg_i.samples) > MaxSamples) begin
      smp_eff = SmpW'(MaxSamples);
    end else begin
      smp_eff = SmpW'(cfg_i.samples);
    end
    rx_bytes = GrpW'(32'(rx_eff) * iqmfd_pkg::IQ_BYTES_PER_RX);
    iq_total = IqW'(32'(smp_eff) * 32'(rx_bytes));
    if (cfg_i.rate == iqmfd_pkg::RATE_48K) begin
      mic_total = MicW'(32'(smp_eff) * iqmfd_pkg::MIC_BYTES_PER_GROUP);
    end else begin
      mic_total = MicW'(smp_eff);
    end
  end

  always_comb begin
    cur_mic      = frame_start_q ? 1'b0 : mic_phase_q;
    cur_grp      = frame_start_q ? rx_bytes : grp_q;
    cur_iq       = frame_start_q ? iq_total : iq_left_q;
    cur_mic_left = frame_start_q ? mic_total : mic_left_q;
    taken        = (skip_q == 2'd0);
    grp_dec      = (cur_grp != '0) ? cur_grp - GrpW'(1) : cur_grp;

    kind        = iqmfd_pkg::KIND_DROP;
    iq_left_d   = cur_iq;
    mic_left_d  = cur_mic_left;
    mic_phase_d = cur_mic;
    grp_d       = grp_dec;

    if (!cur_mic) begin
      if (cur_iq != '0) begin
        kind      = iqmfd_pkg::KIND_IQ;
        iq_left_d = cur_iq - IqW'(1);
      end
      if (grp_dec == '0) begin
        mic_phase_d = 1'b1;
        grp_d       = GrpW'(iqmfd_pkg::MIC_BYTES_PER_GROUP);
      end
    end else begin
      if (taken && (cur_mic_left != '0)) begin
        kind       = iqmfd_pkg::KIND_MIC;
        mic_left_d = cur_mic_left - MicW'(1);
      end
      if (grp_dec == '0) begin
        mic_phase_d = 1'b0;
        grp_d       = rx_bytes;
      end
    end

    case (cfg_i.rate)
      iqmfd_pkg::RATE_192K: skip_reload = iqmfd_pkg::SKIP_AT_192K;
      iqmfd_pkg::RATE_384K: skip_reload = iqmfd_pkg::SKIP_AT_384K;
      default:              skip_reload = 2'd0;
    endcase

    skip_d        = skip_q;
    frame_start_d = 1'b0;
    if (frame_last_i) begin
      skip_d        = taken ? skip_reload : skip_q - 2'd1;
      frame_start_d = 1'b1;
    end
  end

  assign result_o = '{
    out_byte:  data_byte_i,
    kind:      kind,
    frame_end: frame_last_i,
    taken:     taken
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
      mic_phase_q   <= 1'b0;
      grp_q         <= '0;
      iq_left_q     <= '0;
      mic_left_q    <= '0;
      skip_q        <= 2'd0;
    end else if (accept_i) begin
      frame_start_q <= frame_start_d;
      mic_phase_q   <= mic_phase_d;
      grp_q         <= grp_d;
      iq_left_q     <= iq_left_d;
      mic_left_q    <= mic_left_d;
      skip_q        <= skip_d;
    end
  end

  a_last_restarts_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && frame_last_i |=> frame_start_q)
    else $error("frame end did not arm the frame restart");

  a_no_mic_when_skipped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (skip_q != 2'd0) |-> result_o.kind != iqmfd_pkg::KIND_MIC)
    else $error("mic byte kept in a skipped frame");

  a_mic_pair_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mic_phase_q && !frame_start_q |-> grp_q <= GrpW'(iqmfd_pkg::MIC_BYTES_PER_GROUP))
    else $error("mic phase count exceeds one pair");

  a_iq_only_in_iq_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && mic_phase_q && !frame_start_q |-> result_o.kind != iqmfd_pkg::KIND_IQ)
    else $error("IQ byte kept during mic phase");

endmodule

FILE: hw/rtl/iqmfd_queue.sv
// ----------------------------------------------------------------------------
// IQ/mic frame demux result queue
// Two-entry queue that decouples the classifier from the output handshake.
// ----------------------------------------------------------------------------
module iqmfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  iqmfd_pkg::result_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output iqmfd_pkg::result_t head_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  iqmfd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IQ/mic frame demux testbench
// Streams receiver frames through the demultiplexer under random input gaps
// and output stalls, one long output hold among them, and several register
// settings. A local classifier predicts the tag of every byte, and each
// result transaction is checked field by field against it, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_RX         = 8;
  localparam int MAX_SMP        = 1023;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 11;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i  = 8'd0;
  logic       frame_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] stream_kind_o;
  logic       frame_end_o;
  logic       mic_block_taken_o;
  logic       cfg_valid_i  = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i  = 2'd0;
  logic [9:0] cfg_data_i   = 10'd0;

  iq_mic_frame_demux #(
    .MAX_RECEIVERS(MAX_RX),
    .MAX_SAMPLES  (MAX_SMP)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .frame_last_i     (frame_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .stream_kind_o    (stream_kind_o),
    .frame_end_o      (frame_end_o),
    .mic_block_taken_o(mic_block_taken_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  frame_byte_t         tx_bytes[$];
  iqmfd_pkg::result_t  tag_queue[$];

  logic [3:0]      rx_reg    = 4'd1;
  logic [9:0]      smp_reg   = 10'd63;
  iqmfd_pkg::rate_e rate_reg = iqmfd_pkg::RATE_48K;
  logic            mic_phase = 1'b0;
  int unsigned     grp_left  = 0;
  int unsigned     iq_left   = 0;
  int unsigned     mic_left  = 0;
  logic [1:0]      skip_cnt  = 2'd0;
  logic            restart   = 1'b1;

  bit in_took    = 1'b0;
  int in_gap     = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_req   = 1'b0;
  int idle_odds  = 4;
  int quiet      = 0;
  int errors     = 0;
  int n_bytes    = 0;
  int n_frames   = 0;
  int n_settings = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned rx_eff(logic [3:0] r);
    if (r == 4'd0) return 1;
    if (r > MAX_RX) return MAX_RX;
    return r;
  endfunction

  function automatic iqmfd_pkg::result_t classify_byte(logic [7:0] b, logic last);
    iqmfd_pkg::result_t res;
    int unsigned        n;
    res.out_byte  = b;
    res.kind      = iqmfd_pkg::KIND_DROP;
    res.frame_end = last;
    if (restart) begin
      n         = (smp_reg > MAX_SMP) ? MAX_SMP : smp_reg;
      mic_phase = 1'b0;
      grp_left  = rx_eff(rx_reg) * iqmfd_pkg::IQ_BYTES_PER_RX;
      iq_left   = n * rx_eff(rx_reg) * iqmfd_pkg::IQ_BYTES_PER_RX;
      mic_left  = (rate_reg == iqmfd_pkg::RATE_48K) ? n * iqmfd_pkg::MIC_BYTES_PER_GROUP : n;
      restart   = 1'b0;
    end
    res.taken = (skip_cnt == 2'd0);
    if (!mic_phase) begin
      if (iq_left > 0) begin
        res.kind = iqmfd_pkg::KIND_IQ;
        iq_left--;
      end
      if (grp_left > 0) grp_left--;
      if (grp_left == 0) begin
        mic_phase = 1'b1;
        grp_left  = iqmfd_pkg::MIC_BYTES_PER_GROUP;
      end
    end else begin
      if (res.taken && mic_left > 0) begin
        res.kind = iqmfd_pkg::KIND_MIC;
        mic_left--;
      end
      if (grp_left > 0) grp_left--;
      if (grp_left == 0) begin
        mic_phase = 1'b0;
        grp_left  = rx_eff(rx_reg) * iqmfd_pkg::IQ_BYTES_PER_RX;
      end
    end
    if (last) begin
      if (skip_cnt != 2'd0) skip_cnt--;
      else if (rate_reg == iqmfd_pkg::RATE_192K) skip_cnt = iqmfd_pkg::SKIP_AT_192K;
      else if (rate_reg == iqmfd_pkg::RATE_384K) skip_cnt = iqmfd_pkg::SKIP_AT_384K;
      restart = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    iqmfd_pkg::result_t want;
    bit                 moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (iqmfd_pkg::cfg_reg_e'(cfg_index_i))
          iqmfd_pkg::REG_RX_COUNT: rx_reg = cfg_data_i[3:0];
          iqmfd_pkg::REG_SAMPLES:  smp_reg = cfg_data_i;
          iqmfd_pkg::REG_RATE:     rate_reg = iqmfd_pkg::rate_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (tag_queue.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, byte %0h", $time, out_byte_o);
        end else begin
          want = tag_queue.pop_front();
          if (out_byte_o !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %0h, got %0h", $time, want.out_byte, out_byte_o);
          end
          if (stream_kind_o !== want.kind) begin
            errors++;
            $display("%0t: stream_kind expected %0d, got %0d", $time, want.kind,
                     stream_kind_o);
          end
          if (frame_end_o !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                     frame_end_o);
          end
          if (mic_block_taken_o !== want.taken) begin
            errors++;
            $display("%0t: mic_block_taken expected %0b, got %0b", $time, want.taken,
                     mic_block_taken_o);
          end
          if (want.frame_end) n_frames++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        tag_queue.push_back(classify_byte(data_byte_i, frame_last_i));
        in_took = 1'b1;
        n_bytes++;
      end
    end
    if (moved) begin
      quiet = 0;
    end else if (++quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    frame_byte_t nxt;
    if (!in_valid_i || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (tx_bytes.size() > 0) begin
        nxt = tx_bytes.pop_front();
        data_byte_i  <= nxt.data;
        frame_last_i <= nxt.last;
        in_valid_i   <= 1'b1;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          in_gap = $urandom_range(1, 16);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_byte(logic [7:0] data, logic last);
    frame_byte_t fb;
    fb.data = data;
    fb.last = last;
    tx_bytes.push_back(fb);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (tx_bytes.size() != 0 || tag_queue.size() != 0 || in_valid_i);
  endtask

  task automatic write_reg(iqmfd_pkg::cfg_reg_e idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_config(logic [3:0] rx, logic [9:0] smp, iqmfd_pkg::rate_e rate);
    wait_idle();
    write_reg(iqmfd_pkg::REG_RX_COUNT, {6'($urandom), rx});
    write_reg(iqmfd_pkg::REG_SAMPLES, smp);
    write_reg(iqmfd_pkg::REG_RATE, {8'($urandom), rate});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic add_frames(int budget);
    int sent;
    int glen;
    int groups;
    int len;
    int pick;
    sent = 0;
    while (sent < budget) begin
      glen   = rx_eff(rx_reg) * iqmfd_pkg::IQ_BYTES_PER_RX + iqmfd_pkg::MIC_BYTES_PER_GROUP;
      groups = (smp_reg >= 1 && smp_reg <= 6) ? int'(smp_reg) : $urandom_range(1, 3);
      pick   = $urandom_range(0, 9);
      if (pick < 7) len = groups * glen;
      else if (pick == 7) len = groups * glen + $urandom_range(1, 2 * glen);
      else len = $urandom_range(1, 2 * glen);
      for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    logic [3:0] rx;
    logic [9:0] smp;
    int         pick;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short frames at the reset settings, then zero receivers and zero samples.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h33, 1'b1);
    push_byte(8'hCC, 1'b1);
    set_config(4'd0, 10'd0, iqmfd_pkg::RATE_384K);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h5A, 1'b1);
    push_byte(8'hA5, 1'b1);
    for (int i = 0; i < 8; i++) push_byte(8'(i * 37), i == 7);

    for (int phase = 0; phase < PHASES; phase++) begin
      rx   = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 9);
      if (pick == 0) smp = 10'd0;
      else if (pick == 1) smp = 10'd1023;
      else if (pick == 2) smp = 10'($urandom_range(7, 1022));
      else smp = 10'($urandom_range(1, 6));
      case (phase)
        0: set_config(4'd15, 10'd1023, iqmfd_pkg::RATE_384K);
        1: set_config(4'd1, 10'd1, iqmfd_pkg::RATE_48K);
        2: set_config(4'd8, 10'd2, iqmfd_pkg::RATE_192K);
        3: set_config(4'd3, 10'd4, iqmfd_pkg::RATE_96K);
        default: set_config(rx, smp, iqmfd_pkg::rate_e'($urandom_range(0, 3)));
      endcase
      if (phase == PHASES - 1) idle_odds = 0;
      else idle_odds = (phase % 3 == 1) ? 0 : $urandom_range(2, 10);
      if (phase == 4) hold_req = 1'b1;
      add_frames(70);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d bytes in %0d frames over %0d register settings,", n_bytes,
             n_frames, n_settings);
    $display("with random gaps and stalls and one long output hold.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/iqmfd_pkg.sv
hw/rtl/iqmfd_classify.sv
hw/rtl/iqmfd_queue.sv
hw/rtl/iq_mic_frame_demux.sv
dv/tb.sv
